// File: rtl/mp3fs_pkg.sv
// ============================================================================
// mp3fs_pkg: shared types and tables of the Layer III frame sync scanner
// Holds the sequencer states, header field constants and the bitrate and
// sample rate lookup tables.
// ============================================================================
package mp3fs_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    // Result word: 74 payload bits padded to whole bytes.
    localparam int OUT_BITS  = 74;
    localparam int OUT_W     = 80;

    localparam logic [10:0] SYNC_MASK   = 11'h7FF;
    localparam logic [1:0]  VER_MPEG1   = 2'd3;
    localparam logic [1:0]  VER_RESERVED = 2'd1;
    localparam logic [1:0]  LAYER_III   = 2'd1;
    localparam logic [3:0]  BRI_FREE    = 4'd0;
    localparam logic [3:0]  BRI_BAD     = 4'd15;
    localparam logic [1:0]  SRI_BAD     = 2'd3;

    // Coefficient times the kbps-to-bps scale (144 * 1000 and 72 * 1000).
    localparam logic [17:0] COEF_K_MPEG1 = 18'd144000;
    localparam logic [17:0] COEF_K_OTHER = 18'd72000;

    // The dividend stays below 2^26 and the quotient below 2^11.
    localparam int NUM_W     = 26;
    localparam int QUO_W     = 11;
    localparam logic [3:0] DIV_STEPS = 4'd11;
    localparam logic [10:0] HDR_BYTES = 11'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } t_state;

    function automatic logic [8:0] kbps_lookup(input logic mpeg1, input logic [3:0] bri);
        logic [8:0] v;
        if (mpeg1) begin
            case (bri)
                4'd1:    v = 9'd32;
                4'd2:    v = 9'd40;
                4'd3:    v = 9'd48;
                4'd4:    v = 9'd56;
                4'd5:    v = 9'd64;
                4'd6:    v = 9'd80;
                4'd7:    v = 9'd96;
                4'd8:    v = 9'd112;
                4'd9:    v = 9'd128;
                4'd10:   v = 9'd160;
                4'd11:   v = 9'd192;
                4'd12:   v = 9'd224;
                4'd13:   v = 9'd256;
                4'd14:   v = 9'd320;
                default: v = 9'd0;
            endcase
        end else begin
            case (bri)
                4'd1:    v = 9'd8;
                4'd2:    v = 9'd16;
                4'd3:    v = 9'd24;
                4'd4:    v = 9'd32;
                4'd5:    v = 9'd40;
                4'd6:    v = 9'd48;
                4'd7:    v = 9'd56;
                4'd8:    v = 9'd64;
                4'd9:    v = 9'd80;
                4'd10:   v = 9'd96;
                4'd11:   v = 9'd112;
                4'd12:   v = 9'd128;
                4'd13:   v = 9'd144;
                4'd14:   v = 9'd160;
                default: v = 9'd0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] v;
        case ({ver, sri})
            4'b00_00: v = 16'd11025;
            4'b00_01: v = 16'd12000;
            4'b00_10: v = 16'd8000;
            4'b10_00: v = 16'd22050;
            4'b10_01: v = 16'd24000;
            4'b10_10: v = 16'd16000;
            4'b11_00: v = 16'd44100;
            4'b11_01: v = 16'd48000;
            4'b11_10: v = 16'd32000;
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/mp3_frame_sync_scanner.sv
// ============================================================================
// mp3_frame_sync_scanner: MPEG audio Layer III frame sync search
// Scans a byte stream for Layer III frame headers, reports each frame's
// offset, size and header fields, and skips over the frame body.
// ============================================================================
// The scanner takes one file byte per request on the input stream, with tlast
// marking the final byte of the file (that byte is never checked as a header
// end and it returns the window, position and skip count to their reset
// values). Ordinary bytes, body bytes being skipped and bytes that do not
// complete a valid header never hold the input off. A byte that completes a
// valid Layer III header holds the input stream off while the dividend
// coef*kbps*1000 is formed in a single multiplier, a restoring divider
// produces one quotient bit per cycle against the sample rate, and the
// result register is loaded. That last step waits while an earlier result
// is still unread. Results leave through a registered output stage, so the
// scanner keeps taking bytes while a result waits. The frame offset counter
// is OFFSET_BITS wide and wraps; the reported offset is its low 32 bits.
module mp3_frame_sync_scanner #(
    parameter int OFFSET_BITS = mp3fs_pkg::OFFSET_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  logic                       s_axis_tlast,   // final_byte
    // Result stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // From bit 0 up: frame_offset(32), frame_bytes(11), mpeg_version(2),
    // sample_rate_hz(16), bitrate_kbps(9), stereo_mode(2), padding_flag(1),
    // crc_absent(1), then zero fill.
    output logic [mp3fs_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int NUM_W = mp3fs_pkg::NUM_W;
    localparam int QUO_W = mp3fs_pkg::QUO_W;

    // Sequencer and scan state.
    mp3fs_pkg::t_state r_state, n_state;
    logic [23:0]            r_window, n_window;
    logic [1:0]             r_fill,   n_fill;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [10:0]            r_skip,   n_skip;

    // Captured header fields of the frame in progress.
    logic [31:0] r_off,  n_off;
    logic [1:0]  r_ver,  n_ver;
    logic [15:0] r_rate, n_rate;
    logic [8:0]  r_kbps, n_kbps;
    logic [1:0]  r_mode, n_mode;
    logic        r_pad,  n_pad;
    logic        r_crc,  n_crc;

    // Divider registers.
    logic [15:0]      r_rem,   n_rem;
    logic [QUO_W-1:0] r_numlo, n_numlo;
    logic [QUO_W-1:0] r_quo,   n_quo;
    logic [3:0]       r_cnt,   n_cnt;

    // Output stage.
    logic                          r_out_valid, n_out_valid;
    logic [mp3fs_pkg::OUT_W-1:0]   r_out_data,  n_out_data;

    // Candidate header and its fields.
    logic [31:0] hdr;
    logic [1:0]  h_ver, h_lay, h_sri;
    logic [3:0]  h_bri;
    logic        hdr_ok;
    logic        in_fire;
    logic        out_free;

    // Datapath helpers.
    logic [17:0]            coef_k;
    logic [26:0]            product;
    logic [NUM_W-1:0]       dividend;
    logic [16:0]            trial;
    logic                   trial_ge;
    logic [10:0]            size;
    logic [OFFSET_BITS-1:0] here_off;
    logic [OFFSET_BITS+31:0] off_ext;

    assign s_axis_tready = (r_state == mp3fs_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign hdr   = {r_window, s_axis_tdata};
    assign h_ver = hdr[20:19];
    assign h_lay = hdr[18:17];
    assign h_bri = hdr[15:12];
    assign h_sri = hdr[11:10];
    assign hdr_ok = (hdr[31:21] == mp3fs_pkg::SYNC_MASK)
                 && (h_ver != mp3fs_pkg::VER_RESERVED)
                 && (h_lay == mp3fs_pkg::LAYER_III)
                 && (h_bri != mp3fs_pkg::BRI_FREE)
                 && (h_bri != mp3fs_pkg::BRI_BAD)
                 && (h_sri != mp3fs_pkg::SRI_BAD);

    // Offset of the first header byte; the wide copy lets any counter width
    // present exactly 32 bits.
    assign here_off = r_pos - OFFSET_BITS'(3);
    assign off_ext  = {32'd0, here_off};

    // Single multiplier: coef * 1000 * kbps.
    assign coef_k   = (r_ver == mp3fs_pkg::VER_MPEG1) ? mp3fs_pkg::COEF_K_MPEG1
                                                      : mp3fs_pkg::COEF_K_OTHER;
    assign product  = coef_k * r_kbps;
    assign dividend = product[NUM_W-1:0];

    // One restoring divider step: bring down the next dividend bit.
    assign trial    = {r_rem, r_numlo[QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, r_rate});

    assign size = r_quo + {10'd0, r_pad};

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_off       = r_off;
        n_ver       = r_ver;
        n_rate      = r_rate;
        n_kbps      = r_kbps;
        n_mode      = r_mode;
        n_pad       = r_pad;
        n_crc       = r_crc;
        n_rem       = r_rem;
        n_numlo     = r_numlo;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mp3fs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tlast) begin
                        // End of file: window, fill, position and skip back to their reset values.
                        n_window = '0;
                        n_fill   = '0;
                        n_pos    = '0;
                        n_skip   = '0;
                    end else begin
                        n_pos = r_pos + OFFSET_BITS'(1);
                        if (r_skip != 11'd0) begin
                            n_skip = r_skip - 11'd1;
                        end else if (r_fill == 2'd3) begin
                            if (hdr_ok) begin
                                n_off    = off_ext[31:0];
                                n_ver    = h_ver;
                                n_rate   = mp3fs_pkg::rate_lookup(h_ver, h_sri);
                                n_kbps   = mp3fs_pkg::kbps_lookup(
                                               h_ver == mp3fs_pkg::VER_MPEG1, h_bri);
                                n_mode   = hdr[7:6];
                                n_pad    = hdr[9];
                                n_crc    = hdr[16];
                                n_window = '0;
                                n_fill   = '0;
                                n_state  = mp3fs_pkg::ST_MUL;
                            end else begin
                                n_window = hdr[23:0];
                            end
                        end else begin
                            n_window = {r_window[15:0], s_axis_tdata};
                            n_fill   = r_fill + 2'd1;
                        end
                    end
                end
            end
            mp3fs_pkg::ST_MUL: begin
                // The quotient fits 11 bits, so the upper dividend bits
                // already sit below the divisor.
                n_rem   = {1'b0, dividend[NUM_W-1:QUO_W]};
                n_numlo = dividend[QUO_W-1:0];
                n_quo   = '0;
                n_cnt   = '0;
                n_state = mp3fs_pkg::ST_DIV;
            end
            mp3fs_pkg::ST_DIV: begin
                n_rem   = trial_ge ? 16'(trial - {1'b0, r_rate}) : trial[15:0];
                n_numlo = {r_numlo[QUO_W-2:0], 1'b0};
                n_quo   = {r_quo[QUO_W-2:0], trial_ge};
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt == mp3fs_pkg::DIV_STEPS - 4'd1) begin
                    n_state = mp3fs_pkg::ST_LOAD;
                end
            end
            mp3fs_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(mp3fs_pkg::OUT_W - mp3fs_pkg::OUT_BITS){1'b0}},
                                   r_crc, r_pad, r_mode, r_kbps, r_rate, r_ver,
                                   size, r_off};
                    n_skip      = size - mp3fs_pkg::HDR_BYTES;
                    n_state     = mp3fs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mp3fs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mp3fs_pkg::ST_IDLE;
            r_window    <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_skip      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_skip      <= n_skip;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_off      <= n_off;
        r_ver      <= n_ver;
        r_rate     <= n_rate;
        r_kbps     <= n_kbps;
        r_mode     <= n_mode;
        r_pad      <= n_pad;
        r_crc      <= n_crc;
        r_rem      <= n_rem;
        r_numlo    <= n_numlo;
        r_quo      <= n_quo;
        r_out_data <= n_out_data;
    end

    // The divider never runs past its step count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mp3fs_pkg::ST_DIV) |-> (r_cnt < mp3fs_pkg::DIV_STEPS))
        else $error("divider step count overrun");

    // A byte taken while skipping a frame body never starts a new frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_skip != 11'd0) |=> (r_state == mp3fs_pkg::ST_IDLE))
        else $error("frame started inside a skipped body");

    // The window stays empty while a frame is being measured.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mp3fs_pkg::ST_IDLE) |-> (r_fill == 2'd0))
        else $error("window filled during frame work");

    // Loading a result always arms a nonzero body skip.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mp3fs_pkg::ST_LOAD && out_free) |=> (r_out_valid && r_skip != 11'd0))
        else $error("result loaded without body skip");

endmodule
